// File: rtl/core/json_string_unescape_utf8_assert.svh
// ----------------------------------------------------------------------------
// JSON string unescape assertion macros
// Shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled during reset.
`define JSU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("json unescape check failed");

// Next-cycle implication, sampled on clk, disabled during reset.
`define JSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("json unescape check failed");

`endif

// File: rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types, character codes and decode functions.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    localparam int COUNT_BITS = 24;
    localparam int TOTAL_BITS = 24;
    localparam int MAX_RES    = 4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] HIGH_FIRST = 16'hd800;
    localparam logic [15:0] HIGH_LAST  = 16'hdbff;
    localparam logic [15:0] LOW_FIRST  = 16'hdc00;
    localparam logic [15:0] LOW_LAST   = 16'hdfff;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STR,
        PH_ESC,
        PH_HIGH,
        PH_AFTER_HIGH,
        PH_AFTER_BS,
        PH_LOW
    } phase_t;

    typedef struct packed {
        logic       en;
        kind_t      kind;
        logic [7:0] data;
        phase_t     ph;
    } tail_t;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] data;
    } enc_t;

    typedef struct packed {
        logic [2:0]            cnt;
        logic [3:0][1:0]       kinds;
        logic [3:0][7:0]       data;
        logic [TOTAL_BITS-1:0] total;
    } bundle_t;

    // Bit 4 flags a byte that is not a hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] v;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, 4'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b0, 4'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b0, 4'(b - 8'h37)};
        end
        else begin
            v = 5'h10;
        end
        return v;
    endfunction

    function automatic enc_t utf8_encode(input logic [20:0] cp);
        enc_t e;
        e = '0;
        if (cp <= 21'h7f) begin
            e.cnt = 3'd1;
            e.data[0] = cp[7:0];
        end
        else if (cp <= 21'h7ff) begin
            e.cnt = 3'd2;
            e.data[0] = 8'hc0 | {3'b000, cp[10:6]};
            e.data[1] = 8'h80 | {2'b00, cp[5:0]};
        end
        else if (cp <= 21'hffff) begin
            e.cnt = 3'd3;
            e.data[0] = 8'he0 | {4'b0000, cp[15:12]};
            e.data[1] = 8'h80 | {2'b00, cp[11:6]};
            e.data[2] = 8'h80 | {2'b00, cp[5:0]};
        end
        else begin
            e.cnt = 3'd4;
            e.data[0] = 8'hf0 | {5'b00000, cp[20:18]};
            e.data[1] = 8'h80 | {2'b00, cp[17:12]};
            e.data[2] = 8'h80 | {2'b00, cp[11:6]};
            e.data[3] = 8'h80 | {2'b00, cp[5:0]};
        end
        return e;
    endfunction

    // A byte inside the string body.
    function automatic tail_t str_step(input logic [7:0] b);
        tail_t t;
        t.en = 1'b1;
        t.kind = KIND_DATA;
        t.data = b;
        t.ph = PH_STR;
        if (b == CH_NUL) begin
            t.kind = KIND_ERROR;
            t.data = '0;
            t.ph = PH_IDLE;
        end
        else if (b == CH_QUOTE) begin
            t.kind = KIND_END;
            t.data = '0;
            t.ph = PH_IDLE;
        end
        else if (b == CH_BSLASH) begin
            t.en = 1'b0;
            t.data = '0;
            t.ph = PH_ESC;
        end
        return t;
    endfunction

    // The letter after a backslash.
    function automatic tail_t esc_step(input logic [7:0] b);
        tail_t t;
        t.en = 1'b1;
        t.kind = KIND_DATA;
        t.ph = PH_STR;
        case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: t.data = b;
            CH_B: t.data = 8'h08;
            CH_F: t.data = 8'h0c;
            CH_N: t.data = 8'h0a;
            CH_R: t.data = 8'h0d;
            CH_T: t.data = 8'h09;
            CH_U:
            begin
                t.en = 1'b0;
                t.data = '0;
                t.ph = PH_HIGH;
            end
            default:
            begin
                t.kind = KIND_ERROR;
                t.data = '0;
                t.ph = PH_IDLE;
            end
        endcase
        return t;
    endfunction

    function automatic logic [TOTAL_BITS-1:0] sat_total(input logic [COUNT_BITS-1:0] c);
        logic [32:0] w;
        w = 33'(c);
        return (w > 33'((1 << TOTAL_BITS) - 1)) ? '1 : w[TOTAL_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Input channel: in_valid, in_stall, in_byte carry one byte of JSON text per
// word. Output channel: out_valid, out_stall and the result fields kind,
// out_byte, byte_total and last. Each text byte gives zero to four result
// words; last marks the final word of one text byte.
// A text byte with results, once accepted, is loaded into the output register,
// and its first result shows in the cycle after. Plain text streams at one
// byte per cycle while the receiver does not stall; a byte that yields several
// results holds the output register until the last of them leaves, and the
// next byte is taken in the cycle that the last of them leaves.
// Reset puts the parser in its idle state, outside any string, with the
// byte count at zero and the output register empty.
// When the receiver stalls, the current result word holds and the input
// stalls as soon as the output register is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            in_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 kind,
    output logic [7:0]                 out_byte,
    output logic [TOTAL_BITS-1:0]      byte_total,
    output logic                       last
);

    logic    accept;
    bundle_t bundle;

    assign accept = in_valid && !in_stall;

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .bundle  (bundle)
    );

    jsu_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .bundle     (bundle),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_byte   (out_byte),
        .byte_total (byte_total),
        .last       (last)
    );

endmodule

`default_nettype wire

// File: rtl/core/jsu_decode.sv
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Parser state registers and the single-pass decode of one text byte into
// a bundle of up to four results.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    output bundle_t         bundle
);

    phase_t                phase_reg, phase_next;
    logic [1:0]            digit_reg, digit_next;
    logic [15:0]           high_reg, high_next;
    logic [15:0]           low_reg, low_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic [4:0]            hex;
    logic                  cp_en;
    logic [20:0]           cp;
    tail_t                 tail;
    tail_t                 step;
    enc_t                  enc;
    logic [2:0]            ncp;
    logic [2:0]            ndata;
    logic                  cnt_clear;
    logic [COUNT_BITS:0]   sum;

    assign hex = hex_nibble(in_byte);

    always_comb
    begin
        phase_next = phase_reg;
        digit_next = digit_reg;
        high_next = high_reg;
        low_next = low_reg;
        cnt_clear = 1'b0;
        cp_en = 1'b0;
        cp = 21'(high_reg);
        tail = '0;
        step = '0;
        case (phase_reg)
            PH_STR:
            begin
                tail = str_step(in_byte);
                phase_next = tail.ph;
            end
            PH_ESC:
            begin
                tail = esc_step(in_byte);
                phase_next = tail.ph;
                if (tail.ph == PH_HIGH) begin
                    digit_next = '0;
                    high_next = '0;
                end
            end
            PH_HIGH:
            begin
                if (hex[4]) begin
                    tail = '{en: 1'b1, kind: KIND_ERROR, data: 8'h00, ph: PH_IDLE};
                    phase_next = PH_IDLE;
                end
                else begin
                    high_next = {high_reg[11:0], hex[3:0]};
                    if (digit_reg != 2'd3) begin
                        digit_next = digit_reg + 2'd1;
                    end
                    else begin
                        digit_next = '0;
                        if (high_next >= HIGH_FIRST && high_next <= HIGH_LAST) begin
                            phase_next = PH_AFTER_HIGH;
                        end
                        else begin
                            cp_en = 1'b1;
                            cp = 21'(high_next);
                            phase_next = PH_STR;
                        end
                    end
                end
            end
            PH_AFTER_HIGH:
            begin
                if (in_byte == CH_BSLASH) begin
                    phase_next = PH_AFTER_BS;
                end
                else begin
                    cp_en = 1'b1;
                    tail = str_step(in_byte);
                    phase_next = tail.ph;
                end
            end
            PH_AFTER_BS:
            begin
                if (in_byte == CH_U) begin
                    phase_next = PH_LOW;
                    digit_next = '0;
                    low_next = '0;
                end
                else begin
                    cp_en = 1'b1;
                    tail = esc_step(in_byte);
                    phase_next = tail.ph;
                end
            end
            PH_LOW:
            begin
                if (hex[4]) begin
                    tail = '{en: 1'b1, kind: KIND_ERROR, data: 8'h00, ph: PH_IDLE};
                    phase_next = PH_IDLE;
                end
                else begin
                    low_next = {low_reg[11:0], hex[3:0]};
                    if (digit_reg != 2'd3) begin
                        digit_next = digit_reg + 2'd1;
                    end
                    else begin
                        digit_next = '0;
                        if (low_next < LOW_FIRST || low_next > LOW_LAST) begin
                            tail = '{en: 1'b1, kind: KIND_ERROR, data: 8'h00, ph: PH_IDLE};
                            phase_next = PH_IDLE;
                        end
                        else begin
                            cp_en = 1'b1;
                            cp = SUPP_BASE + {1'b0, high_reg[9:0], low_next[9:0]};
                            phase_next = PH_STR;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (in_byte == CH_QUOTE) begin
                    phase_next = PH_STR;
                    cnt_clear = 1'b1;
                    digit_next = '0;
                end
                else if (in_byte != CH_SPACE && in_byte != CH_LF && in_byte != CH_CR
                         && in_byte != CH_TAB) begin
                    step = '{en: 1'b1, kind: KIND_ERROR, data: 8'h00, ph: PH_IDLE};
                    tail = step;
                end
            end
        endcase
    end

    assign enc = utf8_encode(cp);
    assign ncp = cp_en ? enc.cnt : 3'd0;
    assign ndata = ncp + {2'b00, tail.en && tail.kind == KIND_DATA};
    assign sum = {1'b0, count_reg} + (COUNT_BITS + 1)'(ndata);

    always_comb
    begin
        if (cnt_clear) begin
            count_next = '0;
        end
        else if (sum[COUNT_BITS]) begin
            count_next = '1;
        end
        else begin
            count_next = sum[COUNT_BITS-1:0];
        end
    end

    always_comb
    begin
        bundle.cnt = ncp + {2'b00, tail.en};
        bundle.total = (tail.en && tail.kind == KIND_END) ? sat_total(count_next) : '0;
        for (int i = 0; i < MAX_RES; i++) begin
            if (3'(i) < ncp) begin
                bundle.kinds[i] = KIND_DATA;
                bundle.data[i] = enc.data[i];
            end
            else if (3'(i) == ncp && tail.en) begin
                bundle.kinds[i] = tail.kind;
                bundle.data[i] = tail.data;
            end
            else begin
                bundle.kinds[i] = KIND_DATA;
                bundle.data[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            digit_reg <= '0;
            high_reg <= '0;
            low_reg <= '0;
            count_reg <= '0;
        end
        else if (accept) begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
            high_reg <= high_next;
            low_reg <= low_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/jsu_outbuf.sv
// ----------------------------------------------------------------------------
// JSON string unescape result buffer
// Holds one text byte's results, handing out one word a cycle when unstalled.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_outbuf
    import jsu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire bundle_t               bundle,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 kind,
    output logic [7:0]                 out_byte,
    output logic [TOTAL_BITS-1:0]      byte_total,
    output logic                       last
);

    logic       busy_reg;
    logic [1:0] idx_reg;
    bundle_t    bundle_reg;
    logic       take;

    assign out_valid = busy_reg;
    assign take = busy_reg && !out_stall;
    assign last = ({1'b0, idx_reg} == bundle_reg.cnt - 3'd1);
    assign kind = bundle_reg.kinds[idx_reg];
    assign out_byte = bundle_reg.data[idx_reg];
    assign byte_total = (kind == KIND_END) ? bundle_reg.total : '0;
    assign in_stall = busy_reg && !(take && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (load && bundle.cnt != 3'd0) begin
            busy_reg <= 1'b1;
            idx_reg <= '0;
        end
        else if (take) begin
            if (last) begin
                busy_reg <= 1'b0;
            end
            else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && bundle.cnt != 3'd0) begin
            bundle_reg <= bundle;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/jsu_checker.sv
// ----------------------------------------------------------------------------
// JSON string unescape port checker
// Concurrent checks on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_unescape_utf8_assert.svh"

module jsu_checker
    import jsu_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [1:0]            kind,
    input wire logic [7:0]            out_byte,
    input wire logic [TOTAL_BITS-1:0] byte_total,
    input wire logic                  last
);

    `JSU_ASSERT_NOW(a_more_words_block_input, out_valid && !last, in_stall)
    `JSU_ASSERT_NOW(a_end_or_error_is_last, out_valid && kind != KIND_DATA, last)
    `JSU_ASSERT_NOW(a_total_only_on_end, out_valid && kind != KIND_END, byte_total == '0)
    `JSU_ASSERT_NOW(a_byte_only_on_data, out_valid && kind != KIND_DATA, out_byte == '0)
    `JSU_ASSERT_NEXT(a_stalled_word_holds, out_valid && out_stall,
                     out_valid && $stable(kind) && $stable(out_byte) && $stable(last))

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (.*);

`default_nettype wire
